[sv/fdm_pkg.sv]
`timescale 1ns / 1ps
// fdm_pkg: command codes, beat payload types and drive state type
// for the floppy drive control-line block. No dependencies.
package fdm_pkg;

  localparam int unsigned ID_W = 32;
  localparam int unsigned CYL_W = 7;
  localparam int unsigned IDPOS_W = 5;
  localparam logic [ID_W-1:0] ID_RESET = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_EJECT  = 2'd2,
    CMD_RESET  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t command;
    logic selected;
    logic motor_req;
    logic side_select;
    logic step_pulse;
    logic step_direction;
    logic media_valid;
  } in_item_t;

  typedef struct packed {
    logic             ready_res;
    logic             track0;
    logic             dskchg_n;
    logic             wpro_n;
    logic             id_bit;
    logic [CYL_W-1:0] cylinder;
    logic             head;
    logic             motor_active;
  } out_item_t;

  typedef struct packed {
    logic               motor_spinning;
    logic [CYL_W-1:0]   cylinder_pos;
    logic               head_sel;
    logic               ready_flag;
    logic               track0_flag;
    logic               media_present;
    logic               change_latch;
    logic               write_protect;
    logic               step_armed;
    logic [IDPOS_W-1:0] id_position;
  } drv_state_t;

  localparam drv_state_t STATE_RESET = '{
    motor_spinning: 1'b0,
    cylinder_pos:   '0,
    head_sel:       1'b0,
    ready_flag:     1'b0,
    track0_flag:    1'b1,
    media_present:  1'b0,
    change_latch:   1'b1,
    write_protect:  1'b1,
    step_armed:     1'b1,
    id_position:    '0
  };

endpackage

[sv/fdm_if.sv]
`timescale 1ns / 1ps
// fdm_in_if / fdm_out_if: valid/ready channels carrying one beat each.
// Depends on fdm_pkg for the payload types.
interface fdm_in_if;
  logic               valid;
  logic               ready;
  fdm_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fdm_out_if;
  logic               valid;
  logic               ready;
  fdm_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/fdm_in_stage.sv]
`timescale 1ns / 1ps
// fdm_in_stage: input register holding one accepted beat until the core takes it.
// Depends on fdm_pkg and fdm_in_if.
module fdm_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  fdm_in_if.sink            in_ch,
  output logic              s_valid,
  output fdm_pkg::in_item_t s_data,
  input  logic              s_ready
);
  import fdm_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t data_r;
  logic     take;

  assign in_ch.ready = !valid_r || s_ready;
  assign take        = in_ch.valid && in_ch.ready;
  assign valid_nxt   = take || (valid_r && !s_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= in_ch.data;
    end
  end

  assign s_valid = valid_r;
  assign s_data  = data_r;
endmodule

[sv/fdm_core.sv]
`timescale 1ns / 1ps
// fdm_core: drive state, ID register and result register; one beat per cycle unless out_ch stalls.
// Depends on fdm_pkg and fdm_out_if.
module fdm_core #(
  parameter int CYLINDERS = 80
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s_valid,
  input  fdm_pkg::in_item_t s_data,
  output logic              s_ready,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata,
  fdm_out_if.source         out_ch
);
  import fdm_pkg::*;

  localparam logic [CYL_W-1:0] CYL_MAX = CYL_W'(CYLINDERS - 1);

  drv_state_t      st_r, st_nxt;
  logic [ID_W-1:0] id_r, id_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_r, res;
  logic            fire;
  logic [CYL_W-1:0] cyl_step;

  assign s_ready = !out_valid_r || out_ch.ready;
  assign fire    = s_valid && s_ready;
  assign out_valid_nxt = fire || (out_valid_r && !out_ch.ready);

  always_comb begin
    cyl_step = st_r.cylinder_pos;
    if (s_data.step_direction) begin
      if (st_r.cylinder_pos != '0) cyl_step = st_r.cylinder_pos - 1'b1;
    end else begin
      if (st_r.cylinder_pos < CYL_MAX) cyl_step = st_r.cylinder_pos + 1'b1;
    end
  end

  always_comb begin
    st_nxt = st_r;
    if (fire) begin
      unique case (s_data.command)
        CMD_SAMPLE: begin
          if (!s_data.selected) begin
            if (!st_r.motor_spinning) st_nxt.id_position = st_r.id_position + 1'b1;
          end else begin
            if (s_data.motor_req) begin
              if (!st_r.motor_spinning) begin
                st_nxt.motor_spinning = 1'b1;
                st_nxt.ready_flag     = st_r.media_present;
                st_nxt.id_position    = '0;
              end
            end else if (st_r.motor_spinning) begin
              st_nxt.motor_spinning = 1'b0;
              st_nxt.ready_flag     = 1'b0;
            end
            st_nxt.head_sel = s_data.side_select;
            if (s_data.step_pulse && st_r.step_armed) begin
              st_nxt.step_armed   = 1'b0;
              st_nxt.cylinder_pos = cyl_step;
              st_nxt.change_latch = !st_r.media_present;
            end
            if (!s_data.step_pulse) st_nxt.step_armed = 1'b1;
            st_nxt.track0_flag = (st_nxt.cylinder_pos == '0);
          end
        end
        CMD_INSERT: begin
          st_nxt.media_present = s_data.media_valid;
          st_nxt.change_latch  = 1'b1;
          st_nxt.write_protect = 1'b1;
        end
        CMD_EJECT: begin
          st_nxt.media_present  = 1'b0;
          st_nxt.change_latch   = 1'b1;
          st_nxt.write_protect  = 1'b0;
          st_nxt.ready_flag     = 1'b0;
          st_nxt.motor_spinning = 1'b0;
        end
        CMD_RESET: begin
          st_nxt = STATE_RESET;
          st_nxt.media_present = st_r.media_present;
        end
        default: st_nxt = st_r;
      endcase
    end
  end

  always_comb begin
    id_nxt = id_r;
    priority if (cfg_we) begin
      id_nxt = cfg_wdata;
    end else if (fire && s_data.command == CMD_RESET) begin
      id_nxt = ID_RESET;
    end
  end

  always_comb begin
    res.ready_res    = st_nxt.ready_flag;
    res.track0       = st_nxt.track0_flag;
    res.dskchg_n     = !st_nxt.change_latch;
    res.wpro_n       = !(st_nxt.media_present && st_nxt.write_protect);
    res.id_bit       = id_nxt[~st_nxt.id_position];
    res.cylinder     = st_nxt.cylinder_pos;
    res.head         = st_nxt.head_sel;
    res.motor_active = st_nxt.motor_spinning;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= STATE_RESET;
      id_r        <= ID_RESET;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      id_r        <= id_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;
endmodule

[sv/floppy_drive_mechanics.sv]
`timescale 1ns / 1ps
// floppy_drive_mechanics: top level of the floppy drive control-line block.
// Depends on fdm_pkg, fdm_if, fdm_in_stage and fdm_core.
//
//   channel | dir | handshake          | beat
//   in_ch   | in  | valid/ready        | command + sampled control lines
//   out_ch  | out | valid/ready        | drive status after the command
//   cfg_*   | in  | cfg_we (no stall)  | 32-bit drive ID word
//
// One beat per clock sustained while out_ch is not stalled; an accepted beat passes
// through the input register, then the state update into the result register.
// rst_n is synchronous, active low; it clears both stage valids and the drive state.
// A stalled result holds in out_ch while one more beat waits in the input register.
module floppy_drive_mechanics #(
  parameter int CYLINDERS = 80
) (
  input  logic        clk,
  input  logic        rst_n,
  fdm_in_if.sink      in_ch,
  fdm_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import fdm_pkg::*;

  logic     s_valid;
  logic     s_ready;
  in_item_t s_data;

  fdm_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .s_valid (s_valid),
    .s_data  (s_data),
    .s_ready (s_ready)
  );

  fdm_core #(.CYLINDERS(CYLINDERS)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_valid   (s_valid),
    .s_data    (s_data),
    .s_ready   (s_ready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_ch    (out_ch)
  );
endmodule

[sv/fdm_checker.sv]
`timescale 1ns / 1ps
// fdm_checker: port-level checks on the result channel of floppy_drive_mechanics.
// Depends on fdm_pkg; bound to the top level below.
module fdm_checker #(
  parameter int CYLINDERS = 80
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input fdm_pkg::out_item_t out_data
);
  import fdm_pkg::*;

  localparam logic [CYL_W-1:0] CYL_MAX = CYL_W'(CYLINDERS - 1);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  a_ready_motor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.ready_res |-> out_data.motor_active)
    else $error("ready without spinning motor");

  a_track0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.track0 == (out_data.cylinder == '0)))
    else $error("track0 disagrees with cylinder");

  a_cyl_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.cylinder <= CYL_MAX)
    else $error("cylinder beyond last track");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
endmodule

bind floppy_drive_mechanics fdm_checker #(.CYLINDERS(CYLINDERS)) u_fdm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

[tb/floppy_drive_mechanics_tb.sv]
`timescale 1ns / 1ps
// floppy_drive_mechanics_tb: self-checking bench for the floppy drive control-line block.
// Drives command beats with random gaps and stalls and checks every status beat against a
// built-in drive model. Depends on fdm_pkg, fdm_if and floppy_drive_mechanics.
module floppy_drive_mechanics_tb;
  import fdm_pkg::*;

  localparam int CYLINDERS = 80;
  localparam int LIMIT = 500000;
  localparam int PHASE_ITEMS = 150;

  typedef struct {
    in_item_t  item;
    bit        pinned;
    out_item_t want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  fdm_in_if  in_ch ();
  fdm_out_if out_ch ();

  floppy_drive_mechanics #(.CYLINDERS(CYLINDERS)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  drv_state_t  drv;
  logic [31:0] id_word;
  out_item_t   status_q [$];
  dir_row_t    pin_q [$];
  dir_row_t    dir_rows [$];
  int          errors = 0;
  int          cycles = 0;
  int          n_items = 0;
  bit          no_idle = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("floppy_drive_mechanics_tb: errors");
      $finish;
    end
  end

  task automatic report(string field, int got, int want);
    errors++;
    if (errors <= 100)
      $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
  endtask

  function automatic out_item_t advance_drive(in_item_t it);
    out_item_t r;
    logic      keep;
    case (it.command)
      CMD_SAMPLE: begin
        if (!it.selected) begin
          if (!drv.motor_spinning) drv.id_position = drv.id_position + 1'b1;
        end else begin
          if (it.motor_req) begin
            if (!drv.motor_spinning) begin
              drv.motor_spinning = 1'b1;
              drv.ready_flag = drv.media_present;
              drv.id_position = '0;
            end
          end else if (drv.motor_spinning) begin
            drv.motor_spinning = 1'b0;
            drv.ready_flag = 1'b0;
          end
          drv.head_sel = it.side_select;
          if (it.step_pulse && drv.step_armed) begin
            drv.step_armed = 1'b0;
            if (it.step_direction) begin
              if (drv.cylinder_pos != '0) drv.cylinder_pos = drv.cylinder_pos - 1'b1;
            end else if (drv.cylinder_pos != CYL_W'(CYLINDERS - 1)) begin
              drv.cylinder_pos = drv.cylinder_pos + 1'b1;
            end
            drv.change_latch = !drv.media_present;
          end
          if (!it.step_pulse) drv.step_armed = 1'b1;
          drv.track0_flag = (drv.cylinder_pos == '0);
        end
      end
      CMD_INSERT: begin
        drv.media_present = it.media_valid;
        drv.change_latch = 1'b1;
        drv.write_protect = 1'b1;
      end
      CMD_EJECT: begin
        drv.media_present = 1'b0;
        drv.change_latch = 1'b1;
        drv.write_protect = 1'b0;
        drv.ready_flag = 1'b0;
        drv.motor_spinning = 1'b0;
      end
      default: begin
        keep = drv.media_present;
        drv = STATE_RESET;
        drv.media_present = keep;
        id_word = ID_RESET;
      end
    endcase
    r.ready_res = drv.ready_flag;
    r.track0 = drv.track0_flag;
    r.dskchg_n = !drv.change_latch;
    r.wpro_n = drv.media_present ? !drv.write_protect : 1'b1;
    r.id_bit = id_word[5'd31 - drv.id_position];
    r.cylinder = drv.cylinder_pos;
    r.head = drv.head_sel;
    r.motor_active = drv.motor_spinning;
    return r;
  endfunction

  // model update on every accepted command beat and register write
  always @(posedge clk) begin : track_drive
    out_item_t nxt;
    dir_row_t  pin;
    if (!rst_n) begin
      drv = STATE_RESET;
      id_word = ID_RESET;
    end else begin
      if (cfg_we) id_word = cfg_wdata;
      if (in_ch.valid && in_ch.ready) begin
        nxt = advance_drive(in_ch.data);
        if (pin_q.size() != 0) begin
          pin = pin_q.pop_front();
          if (pin.pinned) nxt = pin.want;
        end
        status_q.push_back(nxt);
      end
    end
  end

  always @(posedge clk) begin : check_status
    out_item_t want;
    out_item_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (status_q.size() == 0) begin
        report("unexpected status beat", int'(got), 0);
      end else begin
        want = status_q.pop_front();
        if (got.ready_res !== want.ready_res) report("ready_res", got.ready_res, want.ready_res);
        if (got.track0 !== want.track0) report("track0", got.track0, want.track0);
        if (got.dskchg_n !== want.dskchg_n) report("dskchg_n", got.dskchg_n, want.dskchg_n);
        if (got.wpro_n !== want.wpro_n) report("wpro_n", got.wpro_n, want.wpro_n);
        if (got.id_bit !== want.id_bit) report("id_bit", got.id_bit, want.id_bit);
        if (got.cylinder !== want.cylinder) report("cylinder", got.cylinder, want.cylinder);
        if (got.head !== want.head) report("head", got.head, want.head);
        if (got.motor_active !== want.motor_active)
          report("motor_active", got.motor_active, want.motor_active);
      end
    end
  end

  initial begin : status_sink
    int w;
    forever begin
      w = no_idle ? 0 : $urandom_range(0, 15);
      if (w != 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  function automatic in_item_t drive_lines(cmd_t c, bit sel, bit mot, bit side, bit stp,
                                           bit dir, bit mv);
    in_item_t it;
    it.command = c;
    it.selected = sel;
    it.motor_req = mot;
    it.side_select = side;
    it.step_pulse = stp;
    it.step_direction = dir;
    it.media_valid = mv;
    return it;
  endfunction

  function automatic void add_row(in_item_t it, bit pinned, out_item_t want);
    dir_row_t r;
    r.item = it;
    r.pinned = pinned;
    r.want = want;
    dir_rows.push_back(r);
  endfunction

  task automatic send_beat(in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    n_items++;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_id(logic [31:0] v);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_segment();
    int       kind;
    int       n;
    bit       dir;
    bit       mot;
    in_item_t it;
    kind = $urandom_range(0, 9);
    no_idle = ($urandom_range(0, 4) == 0);
    if (kind <= 3) begin
      // step sweep: clean edge/release pairs in one direction
      dir = $urandom_range(0, 1);
      mot = ($urandom_range(0, 3) != 0);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 100) : $urandom_range(1, 30);
      repeat (n) begin
        send_beat(drive_lines(CMD_SAMPLE, 1, mot, $urandom_range(0, 1), 1, dir,
                              $urandom_range(0, 1)));
        send_beat(drive_lines(CMD_SAMPLE, 1, mot, $urandom_range(0, 1), 0,
                              $urandom_range(0, 1), $urandom_range(0, 1)));
      end
    end else if (kind <= 5) begin
      // motor off, then a run of deselected beats walking the ID bits
      send_beat(drive_lines(CMD_SAMPLE, 1, 0, $urandom_range(0, 1), $urandom_range(0, 1),
                            $urandom_range(0, 1), $urandom_range(0, 1)));
      repeat ($urandom_range(1, 40)) begin
        it = in_item_t'($urandom_range(0, 255));
        it.command = CMD_SAMPLE;
        it.selected = 1'b0;
        send_beat(it);
      end
    end else if (kind <= 8) begin
      repeat ($urandom_range(1, 20)) begin
        it = in_item_t'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0) it.command = CMD_SAMPLE;
        send_beat(it);
      end
    end else begin
      it = in_item_t'($urandom_range(0, 255));
      n = $urandom_range(0, 19);
      it.command = (n < 9) ? CMD_INSERT : (n < 16) ? CMD_EJECT : CMD_RESET;
      send_beat(it);
    end
  endtask

  initial begin : stimulus
    logic [31:0] id_words [5];
    int          target;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;

    add_row(drive_lines(CMD_SAMPLE, 0, 0, 0, 0, 0, 0), 1,
            {1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 7'd0, 1'b0, 1'b0});
    add_row(drive_lines(CMD_INSERT, 0, 0, 0, 0, 0, 1), 1,
            {1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 7'd0, 1'b0, 1'b0});
    add_row(drive_lines(CMD_SAMPLE, 1, 1, 1, 0, 0, 0), 1,
            {1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 7'd0, 1'b1, 1'b1});
    add_row(drive_lines(CMD_SAMPLE, 1, 1, 0, 1, 1, 0), 1,
            {1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 7'd0, 1'b0, 1'b1});
    add_row(drive_lines(CMD_SAMPLE, 1, 1, 1, 1, 0, 1), 0, '0);
    add_row(drive_lines(CMD_SAMPLE, 1, 1, 0, 0, 0, 0), 0, '0);
    add_row(drive_lines(CMD_SAMPLE, 1, 1, 0, 1, 0, 0), 0, '0);
    add_row(drive_lines(CMD_SAMPLE, 0, 1, 1, 0, 1, 1), 0, '0);
    add_row(drive_lines(CMD_SAMPLE, 1, 1, 1, 0, 0, 0), 0, '0);
    add_row(drive_lines(CMD_SAMPLE, 1, 1, 1, 1, 0, 0), 0, '0);
    add_row(drive_lines(CMD_SAMPLE, 0, 1, 0, 0, 0, 0), 0, '0);
    add_row(drive_lines(CMD_SAMPLE, 1, 1, 0, 1, 0, 0), 0, '0);
    add_row(drive_lines(CMD_SAMPLE, 1, 0, 1, 1, 1, 0), 0, '0);
    add_row(drive_lines(CMD_SAMPLE, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(drive_lines(CMD_EJECT, 1, 1, 1, 1, 1, 1), 0, '0);
    add_row(drive_lines(CMD_SAMPLE, 1, 1, 0, 0, 1, 0), 0, '0);
    add_row(drive_lines(CMD_INSERT, 1, 1, 1, 1, 1, 0), 0, '0);
    add_row(drive_lines(CMD_RESET, 1, 1, 1, 1, 1, 1), 1,
            {1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 7'd0, 1'b0, 1'b0});
    add_row(drive_lines(CMD_INSERT, 0, 0, 0, 0, 0, 1), 0, '0);
    add_row(drive_lines(CMD_SAMPLE, 1, 1, 1, 1, 0, 0), 0, '0);
    add_row(drive_lines(CMD_RESET, 0, 0, 0, 0, 0, 0), 1,
            {1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 7'd0, 1'b0, 1'b0});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      pin_q.push_back(dir_rows[i]);
      send_beat(dir_rows[i].item);
    end

    id_words[0] = 32'h0000_0000;
    id_words[1] = 32'hFFFF_FFFF;
    id_words[2] = 32'h8000_0001;
    id_words[3] = $urandom;
    id_words[4] = $urandom;
    foreach (id_words[p]) begin
      write_id(id_words[p]);
      target = n_items + PHASE_ITEMS;
      while (n_items < target) run_segment();
    end

    in_ch.valid <= 1'b0;
    no_idle = 1'b0;
    @(posedge clk);
    while (status_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("floppy_drive_mechanics_tb: clean");
    end else begin
      $display("floppy_drive_mechanics_tb: errors");
    end
    $finish;
  end

endmodule
